// File: hw/rtl/nsf_pkg.sv
// Shared types, character codes and helpers for the NMEA sentence framer.
package nsf_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned LEN_W  = 11;

  localparam logic [CNT_W-1:0] MAX_LEN_RST = 10'd400;

  // Bytes added around the body: '$', '*', two digits, CR, LF.
  localparam logic [LEN_W-1:0] FRAME_OVERHEAD = 11'd6;

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
  localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7e;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2a;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
  localparam logic [BYTE_W-1:0] PRINT_LO  = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI  = 8'h7e;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_BODY = 3'd1,
    PH_DIG1 = 3'd2,
    PH_DIG2 = 3'd3,
    PH_CR   = 3'd4,
    PH_LF   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADCHAR = 3'd1,
    ST_TOOLONG = 3'd2,
    ST_BADTERM = 3'd3,
    ST_CKSUM   = 3'd4
  } status_t;

  typedef struct packed {
    logic             vld;
    status_t          status;
    logic [LEN_W-1:0] length;
    logic [BYTE_W-1:0] xsum;
  } step_res_t;

  // Uppercase ASCII hex digit for one nibble.
  function automatic logic [BYTE_W-1:0] hex_upper(input logic [3:0] nib);
    logic [BYTE_W-1:0] res;
    if (nib < 4'd10) begin
      res = CH_ZERO + {4'd0, nib};
    end else begin
      res = CH_UPPER_A + {4'd0, nib} - 8'd10;
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/nsf_step.sv
// Per-byte framing step: next phase, count, checksum and optional result.
module nsf_step (
  input  nsf_pkg::phase_t                phase,
  input  logic [nsf_pkg::CNT_W-1:0]      count,
  input  logic [nsf_pkg::BYTE_W-1:0]     xsum,
  input  logic [nsf_pkg::CNT_W-1:0]      max_len,
  input  logic [nsf_pkg::BYTE_W-1:0]     data_byte,
  output nsf_pkg::phase_t                phase_nxt,
  output logic [nsf_pkg::CNT_W-1:0]      count_nxt,
  output logic [nsf_pkg::BYTE_W-1:0]     xsum_nxt,
  output nsf_pkg::step_res_t             res
);
  import nsf_pkg::*;

  logic is_dollar;
  logic too_long;
  logic is_eol;
  logic bad_char;
  logic dig1_ok;
  logic dig2_ok;
  logic reject;
  status_t rej_code;

  assign is_dollar = (data_byte == CH_DOLLAR);
  assign too_long  = ({1'b0, count} + 11'd1) > {1'b0, max_len};
  assign is_eol    = (data_byte == CH_CR) || (data_byte == CH_LF);
  assign bad_char  = (data_byte < PRINT_LO) || (data_byte > PRINT_HI) || is_dollar ||
                     (data_byte == CH_BSLASH) || (data_byte == CH_BANG) ||
                     (data_byte == CH_TILDE);
  assign dig1_ok   = (data_byte == hex_upper(xsum[7:4]));
  assign dig2_ok   = (data_byte == hex_upper(xsum[3:0]));

  // Reject decision per phase, in priority order of the body checks.
  always_comb begin
    reject   = 1'b0;
    rej_code = ST_BADCHAR;
    case (phase)
      PH_BODY: begin
        if (too_long) begin
          reject   = 1'b1;
          rej_code = ST_TOOLONG;
        end else if (data_byte == CH_STAR) begin
          reject = 1'b0;
        end else if (is_eol) begin
          reject   = 1'b1;
          rej_code = ST_BADTERM;
        end else if (bad_char) begin
          reject   = 1'b1;
          rej_code = ST_BADCHAR;
        end
      end
      PH_DIG1: begin
        reject   = !dig1_ok;
        rej_code = ST_CKSUM;
      end
      PH_DIG2: begin
        reject   = !dig2_ok;
        rej_code = ST_CKSUM;
      end
      PH_CR: begin
        reject   = (data_byte != CH_CR);
        rej_code = ST_BADTERM;
      end
      PH_LF: begin
        reject   = (data_byte != CH_LF);
        rej_code = ST_BADTERM;
      end
      default: begin
        reject = 1'b0;
      end
    endcase
  end

  // Next phase.
  always_comb begin
    phase_nxt = PH_HUNT;
    if (reject) begin
      phase_nxt = is_dollar ? PH_BODY : PH_HUNT;
    end else begin
      case (phase)
        PH_BODY: phase_nxt = (data_byte == CH_STAR) ? PH_DIG1 : PH_BODY;
        PH_DIG1: phase_nxt = PH_DIG2;
        PH_DIG2: phase_nxt = PH_CR;
        PH_CR:   phase_nxt = PH_LF;
        PH_LF:   phase_nxt = PH_HUNT;
        default: phase_nxt = is_dollar ? PH_BODY : PH_HUNT;
      endcase
    end
  end

  // Count, checksum and result.
  always_comb begin
    count_nxt  = count;
    xsum_nxt   = xsum;
    res.vld    = 1'b0;
    res.status = ST_OK;
    res.length = '0;
    res.xsum   = xsum;
    if (reject) begin
      res.vld    = 1'b1;
      res.status = rej_code;
      if (is_dollar) begin
        count_nxt = '0;
        xsum_nxt  = '0;
      end
    end else begin
      case (phase)
        PH_BODY: begin
          if (data_byte != CH_STAR) begin
            count_nxt = count + 10'd1;
            xsum_nxt  = xsum ^ data_byte;
          end
        end
        PH_LF: begin
          res.vld    = 1'b1;
          res.length = {1'b0, count} + FRAME_OVERHEAD;
        end
        PH_DIG1, PH_DIG2, PH_CR: begin
          count_nxt = count;
        end
        default: begin
          if (is_dollar) begin
            count_nxt = '0;
            xsum_nxt  = '0;
          end
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/nmea_sentence_framer.sv
// Top level of the NMEA 0183 sentence framer with checksum check.
//
// Takes one received character per item and hunts for '$'. Body bytes are
// range checked, counted and XORed into a running checksum up to '*'; then
// two uppercase hex digits must match the checksum, followed by CR LF. A good
// sentence produces one item with status 0 and the total length (body + 6);
// a rejection produces one item with a reason code (1 bad char, 2 too long,
// 3 bad terminator, 4 checksum mismatch) and length 0. Bytes that neither
// finish nor reject a sentence produce nothing. A rejecting '$' opens a new
// sentence right away. Throughput is one item per cycle while nothing
// stalls: the input byte is registered, and one short compare/XOR step
// updates the framing state and loads the output register. The input
// register only stalls when it holds a byte that produces a result while
// the output register is still full. max_body_length (reset 400) is the
// greatest allowed position of '*' counted from the '$'; write it only
// while the block is idle.
module nmea_sentence_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] status, [13:3] sentence_length,
                                  // [21:14] xor_checksum, [23:22] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data    // [9:0] max_body_length
);
  import nsf_pkg::*;

  // Input register.
  logic              s1_vld_r;
  logic              s1_vld_nxt;
  logic [BYTE_W-1:0] s1_byte_r;

  // Framing state.
  phase_t            phase_r;
  phase_t            phase_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [BYTE_W-1:0] xsum_r;
  logic [BYTE_W-1:0] xsum_nxt;
  logic [CNT_W-1:0]  max_len_r;

  // Output register.
  logic              out_vld_r;
  logic              out_vld_nxt;
  logic [23:0]       out_data_r;

  step_res_t         res;
  logic              out_free;
  logic              s1_adv;
  logic              in_acc;

  nsf_step u_step (
    .phase     (phase_r),
    .count     (count_r),
    .xsum      (xsum_r),
    .max_len   (max_len_r),
    .data_byte (s1_byte_r),
    .phase_nxt (phase_nxt),
    .count_nxt (count_nxt),
    .xsum_nxt  (xsum_nxt),
    .res       (res)
  );

  // Stage 1 retires its byte when it yields nothing or the output slot is free.
  assign out_free   = !out_vld_r || out_tready;
  assign s1_adv     = s1_vld_r && (!res.vld || out_free);
  assign in_tready  = !s1_vld_r || s1_adv;
  assign in_acc     = in_tvalid && in_tready;
  assign s1_vld_nxt = in_acc || (s1_vld_r && !s1_adv);

  always_comb begin
    out_vld_nxt = out_vld_r && !out_tready;
    if (s1_adv && res.vld) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_HUNT;
      count_r   <= '0;
      xsum_r    <= '0;
      max_len_r <= MAX_LEN_RST;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (s1_adv) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        xsum_r  <= xsum_nxt;
      end
      if (cfg_valid) begin
        max_len_r <= cfg_data;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
    end
    if (s1_adv && res.vld) begin
      out_data_r <= {2'b00, res.xsum, res.length, res.status};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

endmodule

// File: hw/rtl/nsf_checker.sv
// Port-level checks for the NMEA sentence framer, bound to the top level.
module nsf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  import nsf_pkg::*;

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Rejections carry zero length.
  a_rej_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != ST_OK) |-> (out_tdata[13:3] == 11'd0))
    else $error("rejection with nonzero length");

  // Accepted sentences span at least the framing bytes and fit the limit.
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == ST_OK) |->
      (out_tdata[13:3] >= FRAME_OVERHEAD) && (out_tdata[13:3] <= 11'd1028))
    else $error("accepted length out of range");

  // No result right after reset.
  a_rst_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind nmea_sentence_framer nsf_checker u_nsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
